// ----- rtl/ucb1_pkg.sv -----
// Package for the UCB1 best-child selector: beat structs, register indexes and
// fixed-point constants. No dependencies.
`default_nettype none
package ucb1_pkg;

    localparam logic [31:0] Ln2Q32 = 32'd2977044472;

    typedef enum logic [1:0] {
        REG_SELECT_MODE = 2'd0,
        REG_EXPLORE_C   = 2'd1,
        REG_RATE_BLACK  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  child_index;
        logic [31:0] black_wins;
        logic [31:0] white_wins;
        logic [31:0] visits;
        logic        child_black_to_move;
        logic [31:0] root_visits;
        logic        is_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  best_index;
        logic [31:0] best_score;
    } t_out_beat;

endpackage
`default_nettype wire

// ----- rtl/ucb1_best_child_select.sv -----
// UCB1 best-child selector top level: a bit-serial divider, logarithm and square root
// score each child and a running maximum picks the best. Depends on ucb1_pkg.
// Win-rate mode, zero visits or root visits under two: load, 48 division steps, update.
// UCB1 mode: load, 48 division steps, log setup, 16 squarings, load, 48 division steps,
// 24 root steps, bonus multiply, update. Children are taken only when idle; a last child
// waits in its update state while an earlier result is held; reset is sync.
`default_nettype none
module ucb1_best_child_select (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire ucb1_pkg::t_in_beat i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output ucb1_pkg::t_out_beat     o_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_LOAD  = 11'b00000000010,
        ST_SHARE = 11'b00000000100,
        ST_LOGN  = 11'b00000001000,
        ST_SQA   = 11'b00000010000,
        ST_SQB   = 11'b00000100000,
        ST_LNLD  = 11'b00001000000,
        ST_DIVQ  = 11'b00010000000,
        ST_SQRT  = 11'b00100000000,
        ST_BONUS = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic        r_mode, r_rate_black;
    logic [23:0] r_explore_c;
    ucb1_pkg::t_in_beat r_item;
    logic [7:0]  r_lead_index;
    logic [31:0] r_lead_score;
    logic        r_have_lead;
    logic        r_out_valid;
    ucb1_pkg::t_out_beat r_out;

    // Shared restoring divider: remainder, dividend/quotient shift register.
    logic [31:0] r_rem;
    logic [47:0] r_quo;
    logic [5:0]  r_cnt;
    logic [32:0] rem_shift;
    logic [33:0] rem_diff;
    logic [47:0] quo_next;
    logic [31:0] r_share;

    // Logarithm: mantissa, square, exponent and fraction bits.
    logic [30:0] r_y;
    logic [61:0] r_prod;
    logic [4:0]  r_k;
    logic [15:0] r_frac;
    logic [4:0]  k_pos;
    logic [52:0] ln_prod;

    // Square root and bonus.
    logic [47:0] r_sq_v;
    logic [23:0] r_sq_rem;
    logic [23:0] r_root;
    logic [26:0] sq_trial;
    logic [47:0] bonus_prod;
    logic [31:0] r_bonus;
    logic [32:0] score_sum;
    logic [31:0] score;
    logic        done_go;
    logic [31:0] w_sel;

    always_comb begin
        k_pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r_item.root_visits[i]) begin
                k_pos = 5'(i);
            end
        end
    end

    assign rem_shift  = {r_rem, r_quo[47]};
    assign rem_diff   = {1'b0, rem_shift} - {2'b00, r_item.visits};
    assign quo_next   = {r_quo[46:0], !rem_diff[33]};
    assign ln_prod    = {32'd0, r_k, r_frac} * {21'd0, ucb1_pkg::Ln2Q32};
    assign sq_trial   = {1'b0, r_sq_rem, r_sq_v[47:46]} - {1'b0, r_root, 2'b01};
    assign bonus_prod = {24'd0, r_explore_c} * {24'd0, r_root};
    assign score_sum  = {1'b0, r_share} + {1'b0, r_bonus};
    assign done_go    = !(r_item.is_last && r_out_valid && !i_ready);

    always_comb begin
        if (r_item.visits == 32'd0) begin
            score = 32'd0;
        end else if (score_sum[32]) begin
            score = 32'hFFFF_FFFF;
        end else begin
            score = score_sum[31:0];
        end
    end

    always_comb begin
        if (r_mode) begin
            w_sel = r_rate_black ? r_item.black_wins : r_item.white_wins;
        end else begin
            w_sel = r_item.child_black_to_move ? r_item.white_wins : r_item.black_wins;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_SHARE;
            end
            ST_SHARE: begin
                if (r_cnt == 6'd47) begin
                    if (r_mode || r_item.visits == 32'd0 || r_item.root_visits < 32'd2) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_LOGN;
                    end
                end
            end
            ST_LOGN: begin
                n_state = ST_SQA;
            end
            ST_SQA: begin
                n_state = ST_SQB;
            end
            ST_SQB: begin
                n_state = (r_cnt == 6'd15) ? ST_LNLD : ST_SQA;
            end
            ST_LNLD: begin
                n_state = ST_DIVQ;
            end
            ST_DIVQ: begin
                if (r_cnt == 6'd47) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_cnt == 6'd23) begin
                    n_state = ST_BONUS;
                end
            end
            ST_BONUS: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (done_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= 1'b0;
            r_explore_c  <= 24'd92682;
            r_rate_black <= 1'b1;
            r_have_lead  <= 1'b0;
            r_lead_index <= 8'd0;
            r_lead_score <= 32'd0;
            r_out_valid  <= 1'b0;
            r_cnt        <= 6'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ucb1_pkg::REG_SELECT_MODE: r_mode       <= i_cfg_data[0];
                    ucb1_pkg::REG_EXPLORE_C:   r_explore_c  <= i_cfg_data[23:0];
                    ucb1_pkg::REG_RATE_BLACK:  r_rate_black <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    r_cnt <= 6'd0;
                end
                ST_SHARE, ST_DIVQ: begin
                    r_cnt <= (r_cnt == 6'd47) ? 6'd0 : r_cnt + 6'd1;
                end
                ST_SQB: begin
                    r_cnt <= (r_cnt == 6'd15) ? 6'd0 : r_cnt + 6'd1;
                end
                ST_SQRT: begin
                    r_cnt <= (r_cnt == 6'd23) ? 6'd0 : r_cnt + 6'd1;
                end
                ST_DONE: begin
                    if (done_go) begin
                        if (r_item.is_last) begin
                            r_out_valid  <= 1'b1;
                            r_have_lead  <= 1'b0;
                            r_lead_index <= 8'd0;
                            r_lead_score <= 32'd0;
                        end else if (!r_have_lead || score > r_lead_score) begin
                            r_have_lead  <= 1'b1;
                            r_lead_index <= r_item.child_index;
                            r_lead_score <= score;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_data;
            end
            ST_LOAD: begin
                r_quo   <= {w_sel, 16'd0};
                r_rem   <= 32'd0;
                r_root  <= 24'd0;
                r_bonus <= 32'd0;
            end
            ST_SHARE, ST_DIVQ: begin
                r_rem <= !rem_diff[33] ? rem_diff[31:0] : rem_shift[31:0];
                r_quo <= quo_next;
                if (r_state == ST_SHARE && r_cnt == 6'd47) begin
                    r_share <= (quo_next[47:32] != 16'd0) ? 32'hFFFF_FFFF : quo_next[31:0];
                end
                if (r_state == ST_DIVQ && r_cnt == 6'd47) begin
                    r_sq_v   <= quo_next;
                    r_sq_rem <= 24'd0;
                end
            end
            ST_LOGN: begin
                r_y    <= (k_pos == 5'd31) ? r_item.root_visits[31:1]
                                           : 31'(r_item.root_visits << (5'd30 - k_pos));
                r_k    <= k_pos;
                r_frac <= 16'd0;
            end
            ST_SQA: begin
                r_prod <= {31'd0, r_y} * {31'd0, r_y};
            end
            ST_SQB: begin
                if (r_prod[61]) begin
                    r_y    <= r_prod[61:31];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_y    <= r_prod[60:30];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
            end
            ST_LNLD: begin
                r_quo <= {11'd0, ln_prod[52:32], 16'd0};
                r_rem <= 32'd0;
            end
            ST_SQRT: begin
                if (!sq_trial[26]) begin
                    r_sq_rem <= sq_trial[23:0];
                    r_root   <= {r_root[22:0], 1'b1};
                end else begin
                    r_sq_rem <= {r_sq_rem[21:0], r_sq_v[47:46]};
                    r_root   <= {r_root[22:0], 1'b0};
                end
                r_sq_v <= {r_sq_v[45:0], 2'b00};
            end
            ST_BONUS: begin
                r_bonus <= bonus_prod[47:16];
            end
            ST_DONE: begin
                if (done_go && r_item.is_last) begin
                    if (!r_have_lead || score > r_lead_score) begin
                        r_out <= '{best_index: r_item.child_index, best_score: score};
                    end else begin
                        r_out <= '{best_index: r_lead_index, best_score: r_lead_score};
                    end
                end
            end
            default: ;
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^{ln_prod[31:0], bonus_prod[15:0], sq_trial[25:24], rem_diff[32]};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_item.is_last && done_go) |=> r_out_valid)
        else $error("result not raised on last child");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_item.is_last && done_go) |=> !r_have_lead)
        else $error("lead not cleared after result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result beat changed while waiting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

endmodule
`default_nettype wire

// ----- sim/ucb1_best_child_select_tb.sv -----
// Self-checking testbench for ucb1_best_child_select: random child runs across
// several register settings, each result checked against a local scoring model.
// Depends on ucb1_pkg and the ucb1_best_child_select RTL.
`timescale 1ns / 1ps
module ucb1_best_child_select_tb;

    localparam int WatchdogLimit = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    ucb1_pkg::t_in_beat  in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    ucb1_pkg::t_out_beat out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_ready_q = 1'b0;

    ucb1_pkg::t_in_beat  child_queue[$];
    ucb1_pkg::t_out_beat best_queue[$];

    logic        mode_win_rate = 1'b0;
    logic [23:0] explore_const = 24'd92682;
    logic        count_black = 1'b1;
    logic [7:0]  lead_idx = '0;
    logic [31:0] lead_val = '0;
    logic        lead_held = 1'b0;

    int  mismatches = 0;
    int  runs_checked = 0;
    int  children_sent = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_send = 1'b0;
    bit  timed_out = 1'b0;

    always #10 clk = ~clk;

    ucb1_best_child_select uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_data),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    function automatic logic [63:0] win_share(logic [63:0] w, logic [63:0] n);
        logic [63:0] ip;
        logic [63:0] rem;
        ip = w / n;
        rem = w % n;
        if (ip > 64'hFFFF) return 64'hFFFF_FFFF;
        return (ip << 16) | ((rem << 16) / n);
    endfunction

    function automatic logic [63:0] natural_log_q16(logic [63:0] x);
        int          top;
        logic [63:0] y;
        logic [63:0] lg;
        top = 0;
        for (int i = 0; i < 64; i++) if (x[i]) top = i;
        y = (top <= 30) ? (x << (30 - top)) : (x >> (top - 30));
        lg = 64'(top) << 16;
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                lg[15 - i] = 1'b1;
            end
        end
        return 64'((128'(lg) * 128'(ucb1_pkg::Ln2Q32)) >> 32);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] child_score(ucb1_pkg::t_in_beat c);
        logic [63:0] w;
        logic [63:0] sc;
        logic [63:0] q;
        if (c.visits == 0) return 32'd0;
        if (mode_win_rate) begin
            w = count_black ? 64'(c.black_wins) : 64'(c.white_wins);
            return 32'(win_share(w, 64'(c.visits)));
        end
        w = c.child_black_to_move ? 64'(c.white_wins) : 64'(c.black_wins);
        sc = win_share(w, 64'(c.visits));
        if (c.root_visits >= 2) begin
            q = (natural_log_q16(64'(c.root_visits)) << 16) / 64'(c.visits);
            sc = sc + ((64'(explore_const) * int_sqrt(q)) >> 16);
        end
        if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
        return 32'(sc);
    endfunction

    task automatic track_child(ucb1_pkg::t_in_beat c);
        logic [31:0] sc;
        ucb1_pkg::t_out_beat best;
        sc = child_score(c);
        if (!lead_held || sc > lead_val) begin
            lead_idx = c.child_index;
            lead_val = sc;
            lead_held = 1'b1;
        end
        if (c.is_last) begin
            best.best_index = lead_idx;
            best.best_score = lead_val;
            best_queue.insert(best_queue.size(), best);
            lead_idx = '0;
            lead_val = '0;
            lead_held = 1'b0;
        end
    endtask

    // The sender is the driver: it presents queued children at the falling edge.
    always @(negedge clk) begin
        if (rst_n && !(in_valid && !in_ready_q)) begin
            if (child_queue.size() != 0 && !hold_send && (calm || $urandom_range(99) >= 17)) begin
                in_data <= child_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && (calm || $urandom_range(99) >= 17);
    end

    always @(posedge clk) in_ready_q <= in_valid && in_ready ? 1'b1 : 1'b0;

    // Sampling at the rising edge: accepted children feed the model and result beats are checked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                track_child(in_data);
                children_sent++;
            end
            if (out_valid && out_ready) begin
                if (best_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat: index %0d score %h",
                                 out_data.best_index, out_data.best_score);
                end else begin
                    if (out_data !== best_queue[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected index %0d score %h, got %0d %h",
                                     best_queue[0].best_index, best_queue[0].best_score,
                                     out_data.best_index, out_data.best_score);
                    end
                    void'(best_queue.pop_front());
                    runs_checked++;
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit && !timed_out) begin
                timed_out = 1'b1;
                $display("Watchdog expired after %0d quiet cycles", idle_cycles);
                $display("ucb1_best_child_select_tb: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_count();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 3);
            3: return $urandom_range(1, 200);
            default: return $urandom;
        endcase
    endfunction

    function automatic ucb1_pkg::t_in_beat rand_child(logic [31:0] root, bit last);
        ucb1_pkg::t_in_beat c;
        c.child_index = 8'($urandom);
        c.visits = rand_count();
        if ($urandom_range(9) == 0) begin
            c.black_wins = rand_count();
            c.white_wins = rand_count();
        end else begin
            c.black_wins = (c.visits == 0) ? 32'd0
                         : 32'(64'($urandom) % (64'(c.visits) + 64'd1));
            c.white_wins = 32'(64'(c.visits) - 64'(c.black_wins));
        end
        c.child_black_to_move = 1'($urandom);
        c.root_visits = root;
        c.is_last = last;
        return c;
    endfunction

    task automatic queue_run(int n);
        logic [31:0] root;
        root = rand_count();
        for (int i = 0; i < n; i++)
            child_queue.insert(child_queue.size(), rand_child(root, i == n - 1));
    endtask

    task automatic wait_drained();
        while (child_queue.size() != 0 || in_valid || best_queue.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(ucb1_pkg::t_reg_idx idx, logic [31:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ucb1_pkg::REG_SELECT_MODE: mode_win_rate = value[0];
            ucb1_pkg::REG_EXPLORE_C:   explore_const = value[23:0];
            default:                   count_black = value[0];
        endcase
    endtask

    task automatic queue_directed();
        ucb1_pkg::t_in_beat c;
        c = '0;
        c.is_last = 1'b1;
        child_queue.insert(child_queue.size(), c);
        c = '{child_index: 8'd255, black_wins: 32'hFFFF_FFFF, white_wins: 32'hFFFF_FFFF,
              visits: 32'd1, child_black_to_move: 1'b1, root_visits: 32'hFFFF_FFFF,
              is_last: 1'b0};
        child_queue.insert(child_queue.size(), c);
        c.child_index = 8'd7; c.child_black_to_move = 1'b0; c.visits = 32'hFFFF_FFFF;
        c.root_visits = 32'd1; c.is_last = 1'b1;
        child_queue.insert(child_queue.size(), c);
        // Equal children: the earlier one must keep the lead.
        c = '{child_index: 8'd3, black_wins: 32'd5, white_wins: 32'd5, visits: 32'd10,
              child_black_to_move: 1'b0, root_visits: 32'd2, is_last: 1'b0};
        child_queue.insert(child_queue.size(), c);
        c.child_index = 8'd4;
        child_queue.insert(child_queue.size(), c);
        c.child_index = 8'd5; c.visits = 32'd0; c.is_last = 1'b1;
        child_queue.insert(child_queue.size(), c);
        c = '{child_index: 8'hAA, black_wins: 32'd0, white_wins: 32'd1, visits: 32'd1,
              child_black_to_move: 1'b1, root_visits: 32'd0, is_last: 1'b1};
        child_queue.insert(child_queue.size(), c);
        for (int i = 0; i < 4; i++) queue_run($urandom_range(2, 5));
    endtask

    task automatic queue_random(int total);
        int sent;
        sent = 0;
        while (sent < total) begin
            int n;
            n = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            queue_run(n);
            sent += n;
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        queue_directed();
        wait_drained();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_reg(ucb1_pkg::REG_EXPLORE_C, 32'd0);
                1: write_reg(ucb1_pkg::REG_EXPLORE_C, 32'h00FF_FFFF);
                2: begin
                    write_reg(ucb1_pkg::REG_SELECT_MODE, 32'd1);
                    write_reg(ucb1_pkg::REG_RATE_BLACK, 32'd0);
                end
                3: write_reg(ucb1_pkg::REG_RATE_BLACK, 32'd1);
                4: begin
                    write_reg(ucb1_pkg::REG_SELECT_MODE, 32'd0);
                    write_reg(ucb1_pkg::REG_EXPLORE_C, 32'($urandom_range(1, 24'hFF_FFFF)));
                end
                default: write_reg(ucb1_pkg::REG_EXPLORE_C, 32'd92682);
            endcase
            calm = (phase == 3);
            queue_random(300);
            if (phase == 1) begin
                // Let every outstanding result arrive before sending more.
                while (child_queue.size() > 150) @(posedge clk);
                hold_send = 1'b1;
                while (in_valid || best_queue.size() != 0) @(posedge clk);
                hold_send = 1'b0;
            end
            wait_drained();
        end
        $display("Covered %0d children in %0d checked runs over both scoring modes,",
                 children_sent, runs_checked);
        $display("extreme and random exploration constants, and both win-rate sides.");
        if (mismatches == 0) begin
            $display("ucb1_best_child_select_tb: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("ucb1_best_child_select_tb: FAIL");
        end
        $finish;
    end
endmodule
